FILE: rtl/core/pct_pkg.sv
// Shared package for the packed coil table: field widths, op codes,
// APB register map and the command/status structs between controller and datapath.
package pct_pkg;

    localparam int NUM_COILS_DEF  = 256;

    localparam int OP_W           = 3;
    localparam int ADDR_W         = 16;
    localparam int CNT_W          = 11;
    localparam int DATA_W         = 8;
    localparam int BASE_W         = 16;

    localparam int MAX_RESULTS    = 32;
    localparam int MAX_READ_COILS = MAX_RESULTS * 8;

    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic [OP_W-1:0] OP_BUS_READ  = 3'd0;
    localparam logic [OP_W-1:0] OP_WR_HEADER = 3'd1;
    localparam logic [OP_W-1:0] OP_WR_DATA   = 3'd2;
    localparam logic [OP_W-1:0] OP_LOC_GET   = 3'd3;
    localparam logic [OP_W-1:0] OP_LOC_SET   = 3'd4;

    // word index of the register (paddr[2])
    localparam logic REG_COIL_BASE = 1'b0;

    localparam logic [DATA_W-1:0] GET_BAD_BYTE = 8'hFF;

    typedef enum logic [2:0] {
        EM_ERR,
        EM_GETBAD,
        EM_RDBYTE,
        EM_GETOK,
        EM_SETOK,
        EM_FIN
    } t_emit;

    typedef struct packed {
        logic  load;
        logic  init;
        logic  step_rej;
        logic  rd_lo;
        logic  rd_hi;
        logic  wr_lo;
        logic  wr_hi;
        logic  emit;
        t_emit kind;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            bus_ok;
        logic            rd_big;
        logic            cnt_zero;
        logic            loc_ok;
        logic            w_open;
        logic            w_rej;
        logic            w_last;
        logic            r_last;
        logic            out_free;
    } t_stat;

endpackage

FILE: rtl/core/pct_if.sv
// Request and result channel interfaces for the packed coil table.
// Depends on pct_pkg for field widths.
interface pct_req_if;
    import pct_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] address;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] data;

    modport source (output valid, op, address, count, data, input ready);
    modport sink   (input valid, op, address, count, data, output ready);
endinterface

interface pct_res_if;
    import pct_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_res;
    logic              status;
    logic              changed;
    logic              last;

    modport source (output valid, data_res, status, changed, last, input ready);
    modport sink   (input valid, data_res, status, changed, last, output ready);
endinterface

FILE: rtl/core/pct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/pct_ctrl.sv
// Sequencer for the packed coil table: accepts one request at a time and
// steps the datapath through byte reads, writes and result emission. Uses pct_pkg.
module pct_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  pct_pkg::t_stat i_stat,
    output pct_pkg::t_cmd  o_cmd
);
    import pct_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD_LO,
        S_RD_HI,
        S_WR_LO,
        S_WR_HI,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    t_emit  r_kind, n_kind;

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        o_cmd       = '0;
        o_cmd.kind  = r_kind;
        o_req_ready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.init = 1'b1;
                n_state    = S_IDLE;
                unique case (i_stat.op)
                    OP_BUS_READ: begin
                        if (i_stat.bus_ok && !i_stat.rd_big) begin
                            n_state = S_RD_LO;
                        end else begin
                            n_kind  = EM_ERR;
                            n_state = S_EMIT;
                        end
                    end
                    OP_WR_HEADER: begin
                        if (i_stat.cnt_zero) begin
                            n_kind  = EM_ERR;
                            n_state = S_EMIT;
                        end
                    end
                    OP_WR_DATA: begin
                        if (i_stat.w_open) begin
                            if (i_stat.w_rej) begin
                                // rejected write: only count bytes down
                                o_cmd.step_rej = 1'b1;
                                if (i_stat.w_last) begin
                                    n_kind  = EM_FIN;
                                    n_state = S_EMIT;
                                end
                            end else begin
                                n_state = S_RD_LO;
                            end
                        end
                    end
                    OP_LOC_GET: begin
                        if (i_stat.loc_ok) begin
                            n_state = S_RD_LO;
                        end else begin
                            n_kind  = EM_GETBAD;
                            n_state = S_EMIT;
                        end
                    end
                    OP_LOC_SET: begin
                        if (i_stat.loc_ok) begin
                            n_state = S_RD_LO;
                        end else begin
                            n_kind  = EM_ERR;
                            n_state = S_EMIT;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_RD_LO: begin
                o_cmd.rd_lo = 1'b1;
                n_state     = S_RD_HI;
            end
            S_RD_HI: begin
                o_cmd.rd_hi = 1'b1;
                if (i_stat.op == OP_BUS_READ) begin
                    n_kind  = EM_RDBYTE;
                    n_state = S_EMIT;
                end else if (i_stat.op == OP_LOC_GET) begin
                    n_kind  = EM_GETOK;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_WR_LO;
                end
            end
            S_WR_LO: begin
                o_cmd.wr_lo = 1'b1;
                n_state     = S_WR_HI;
            end
            S_WR_HI: begin
                o_cmd.wr_hi = 1'b1;
                n_state     = S_IDLE;
                if (i_stat.op == OP_LOC_SET) begin
                    n_kind  = EM_SETOK;
                    n_state = S_EMIT;
                end else if (i_stat.w_last) begin
                    n_kind  = EM_FIN;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_kind == EM_RDBYTE && !i_stat.r_last) begin
                        n_state = S_RD_LO;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= EM_ERR;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end
endmodule

FILE: rtl/core/pct_dp.sv
// Datapath of the packed coil table: request latch, range check, coil RAM
// with per-byte valid bits, bit alignment and the result register. Uses pct_pkg, pct_ram.
module pct_dp #(
    parameter int NUM_COILS = pct_pkg::NUM_COILS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [pct_pkg::OP_W-1:0]    i_op,
    input  logic [pct_pkg::ADDR_W-1:0]  i_address,
    input  logic [pct_pkg::CNT_W-1:0]   i_count,
    input  logic [pct_pkg::DATA_W-1:0]  i_data,
    input  logic [pct_pkg::BASE_W-1:0]  i_coil_base,
    input  pct_pkg::t_cmd               i_cmd,
    output pct_pkg::t_stat              o_stat,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic [pct_pkg::DATA_W-1:0]  o_data_res,
    output logic                        o_status,
    output logic                        o_changed,
    output logic                        o_last
);
    import pct_pkg::*;

    localparam int STORE_BYTES = (NUM_COILS + 7) / 8;
    localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int PW          = $clog2(NUM_COILS);
    localparam int SPAN_W      = BASE_W + 2;

    // latched request
    logic [OP_W-1:0]   r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_data;

    // working cursor and bus read/write progress
    logic [PW-1:0]     r_ptr;
    logic [CNT_W-1:0]  r_rleft;
    logic [PW-1:0]     r_wpos;
    logic [CNT_W-1:0]  r_wleft;
    logic              r_wchg;
    logic              r_wrej;

    logic [DATA_W-1:0] r_lo;
    logic              r_qok;
    logic [STORE_BYTES-1:0] r_valid;

    logic              r_res_valid;
    logic [DATA_W-1:0] r_data_res;
    logic              r_status;
    logic              r_changed;
    logic              r_last;

    logic [ADDR_W-1:0] bus_a;
    logic [ADDR_W-1:0] bus_off;
    logic [SPAN_W-1:0] span_end;
    logic [SPAN_W-1:0] span_lim;
    logic              bus_ok;
    logic              loc_ok;
    logic [AW-1:0]     lo_idx;
    logic [AW:0]       hi_ext;
    logic [AW-1:0]     hi_idx;
    logic              hi_in;
    logic [DATA_W-1:0] ram_q;
    logic [DATA_W-1:0] q_eff;
    logic [15:0]       old16;
    logic [15:0]       win16;
    logic [2:0]        sh;
    logic [3:0]        n_r;
    logic [3:0]        n_w;
    logic [3:0]        n_bits;
    logic [DATA_W-1:0] rmask8;
    logic [DATA_W-1:0] wmask8;
    logic [DATA_W-1:0] wbyte;
    logic [15:0]       wmask16;
    logic [15:0]       wdat16;
    logic [15:0]       new16;
    logic              chg;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;

    // bus range: a = address-1, legal when count>=1 and the span sits in the window
    assign bus_a    = r_addr - ADDR_W'(1);
    assign span_end = SPAN_W'(bus_a) + SPAN_W'(r_cnt);
    assign span_lim = SPAN_W'(i_coil_base) + SPAN_W'(NUM_COILS);
    assign bus_ok   = (r_cnt != '0) && (bus_a >= i_coil_base) && (span_end <= span_lim);
    assign bus_off  = bus_a - i_coil_base;
    assign loc_ok   = (17'(r_addr) < 17'(NUM_COILS));

    assign lo_idx = AW'(r_ptr >> 3);
    assign hi_ext = {1'b0, lo_idx} + (AW + 1)'(1);
    assign hi_in  = (hi_ext < (AW + 1)'(STORE_BYTES));
    assign hi_idx = hi_ext[AW-1:0];

    // never-written bytes read as zero
    assign q_eff = r_qok ? ram_q : '0;
    assign old16 = {q_eff, r_lo};
    assign sh    = r_ptr[2:0];
    assign win16 = old16 >> sh;

    assign n_r    = (r_rleft < CNT_W'(8)) ? r_rleft[3:0] : 4'd8;
    assign n_w    = (r_wleft < CNT_W'(8)) ? r_wleft[3:0] : 4'd8;
    assign n_bits = (r_op == OP_LOC_SET) ? 4'd1 : n_w;
    assign rmask8 = DATA_W'((9'd1 << n_r) - 9'd1);
    assign wmask8 = DATA_W'((9'd1 << n_bits) - 9'd1);
    assign wbyte  = (r_op == OP_LOC_SET) ? {7'd0, r_data[0]} : r_data;

    assign wmask16 = {8'd0, wmask8} << sh;
    assign wdat16  = {8'd0, wbyte} << sh;
    assign new16   = (old16 & ~wmask16) | (wdat16 & wmask16);
    assign chg     = |(old16 ^ new16);

    assign ram_we    = i_cmd.wr_lo || (i_cmd.wr_hi && hi_in);
    assign ram_waddr = i_cmd.wr_hi ? hi_idx : lo_idx;
    assign ram_wdata = i_cmd.wr_hi ? new16[15:8] : new16[7:0];
    assign ram_re    = i_cmd.rd_lo || i_cmd.rd_hi;
    assign ram_raddr = i_cmd.rd_hi ? hi_idx : lo_idx;

    pct_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_addr <= i_address;
            r_cnt  <= i_count;
            r_data <= i_data;
        end
        if (i_cmd.rd_lo) begin
            r_qok <= r_valid[lo_idx];
        end
        if (i_cmd.rd_hi) begin
            r_qok <= hi_in && r_valid[hi_idx];
            r_lo  <= q_eff;
        end
        if (i_cmd.init) begin
            case (r_op)
                OP_BUS_READ: begin
                    r_ptr   <= PW'(bus_off);
                    r_rleft <= r_cnt;
                end
                OP_WR_DATA:  r_ptr <= r_wpos;
                OP_LOC_GET,
                OP_LOC_SET:  r_ptr <= PW'(r_addr);
                default:     r_ptr <= r_ptr;
            endcase
        end
        if (i_cmd.emit) begin
            unique case (i_cmd.kind)
                EM_ERR: begin
                    r_data_res <= '0;
                    r_status   <= 1'b1;
                    r_changed  <= 1'b0;
                    r_last     <= 1'b1;
                end
                EM_GETBAD: begin
                    r_data_res <= GET_BAD_BYTE;
                    r_status   <= 1'b1;
                    r_changed  <= 1'b0;
                    r_last     <= 1'b1;
                end
                EM_RDBYTE: begin
                    r_data_res <= win16[7:0] & rmask8;
                    r_status   <= 1'b0;
                    r_changed  <= 1'b0;
                    r_last     <= (r_rleft <= CNT_W'(8));
                    r_ptr      <= r_ptr + PW'(8);
                    r_rleft    <= r_rleft - CNT_W'(8);
                end
                EM_GETOK: begin
                    r_data_res <= {7'd0, win16[0]};
                    r_status   <= 1'b0;
                    r_changed  <= 1'b0;
                    r_last     <= 1'b1;
                end
                EM_SETOK: begin
                    r_data_res <= '0;
                    r_status   <= 1'b0;
                    r_changed  <= 1'b0;
                    r_last     <= 1'b1;
                end
                EM_FIN: begin
                    r_data_res <= '0;
                    r_status   <= r_wrej;
                    r_changed  <= !r_wrej && r_wchg;
                    r_last     <= 1'b1;
                end
                default: begin
                    r_data_res <= '0;
                    r_status   <= 1'b1;
                    r_changed  <= 1'b0;
                    r_last     <= 1'b1;
                end
            endcase
        end
    end

    // control state: write progress, valid bits, result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos      <= '0;
            r_wleft     <= '0;
            r_wchg      <= 1'b0;
            r_wrej      <= 1'b0;
            r_valid     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cmd.init && r_op == OP_WR_HEADER) begin
                // new header drops any open write
                r_wchg  <= 1'b0;
                r_wleft <= r_cnt;
                r_wrej  <= !bus_ok;
                r_wpos  <= bus_ok ? PW'(bus_off) : '0;
            end
            if (i_cmd.step_rej) begin
                r_wleft <= r_wleft - CNT_W'(n_w);
            end
            if (i_cmd.wr_lo) begin
                r_valid[lo_idx] <= 1'b1;
            end
            if (i_cmd.wr_hi) begin
                if (hi_in) begin
                    r_valid[hi_idx] <= 1'b1;
                end
                if (r_op == OP_WR_DATA) begin
                    r_wpos  <= r_wpos + PW'(n_w);
                    r_wleft <= r_wleft - CNT_W'(n_w);
                    if (chg) begin
                        r_wchg <= 1'b1;
                    end
                end
            end
            if (i_cmd.emit) begin
                r_res_valid <= 1'b1;
                if (i_cmd.kind == EM_FIN) begin
                    r_wchg <= 1'b0;
                    r_wrej <= 1'b0;
                    r_wpos <= '0;
                end
            end else if (r_res_valid && i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    assign o_stat.op       = r_op;
    assign o_stat.bus_ok   = bus_ok;
    assign o_stat.rd_big   = (r_cnt > CNT_W'(MAX_READ_COILS));
    assign o_stat.cnt_zero = (r_cnt == '0);
    assign o_stat.loc_ok   = loc_ok;
    assign o_stat.w_open   = (r_wleft != '0);
    assign o_stat.w_rej    = r_wrej;
    assign o_stat.w_last   = (r_wleft <= CNT_W'(8));
    assign o_stat.r_last   = (r_rleft <= CNT_W'(8));
    assign o_stat.out_free = !r_res_valid || i_res_ready;

    assign o_res_valid = r_res_valid;
    assign o_data_res  = r_data_res;
    assign o_status    = r_status;
    assign o_changed   = r_changed;
    assign o_last      = r_last;
endmodule

FILE: rtl/core/packed_coil_table.sv
// Top level of the packed coil table: APB register, controller and datapath.
// Depends on pct_pkg, pct_if (pct_req_if, pct_res_if), pct_ctrl, pct_dp.
//
//  channel   dir   handshake        contents
//  i_req     in    valid/ready      op, address, count, data
//  o_res     out   valid/ready      data_res, status, changed, last
//  apb       in    psel/penable     coil_base at byte address 0 (pready tied high)
//
// Sequencing: one request is in flight at a time; each is accepted, then decoded.
//   The single read port of the coil RAM sets the pace: every access fetches the
//   two bytes a bit window can straddle, one per cycle, and a write data byte or
//   a local set writes them back one per cycle.
// Reset: synchronous, active low; clears the per-byte valid bits (unwritten
//   bytes read as zero), write progress, coil_base and the handshake state.
// Stalls: a result waiting on ready alone does not block the next request;
//   the sequencer waits in its emit step until the result register is free,
//   and the request port stays low while it waits.
module packed_coil_table #(
    parameter int NUM_COILS = pct_pkg::NUM_COILS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pct_pkg::PADDR_W-1:0]  paddr,
    input  logic [pct_pkg::PDATA_W-1:0]  pwdata,
    output logic [pct_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    pct_req_if.sink                      i_req,
    pct_res_if.source                    o_res
);
    import pct_pkg::*;

    logic [BASE_W-1:0] r_coil_base;
    logic              cfg_sel;
    logic              req_ready;
    t_cmd              cmd;
    t_stat             stat;

    // Register file: one register, word index in paddr[2]; byte lanes ignored.
    assign cfg_sel = (paddr[2] == REG_COIL_BASE);
    assign pready  = 1'b1;
    assign prdata  = cfg_sel ? PDATA_W'(r_coil_base) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coil_base <= '0;
        end else if (psel && penable && pwrite && cfg_sel) begin
            r_coil_base <= pwdata[BASE_W-1:0];
        end
    end

    assign i_req.ready = req_ready;

    pct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pct_dp #(
        .NUM_COILS (NUM_COILS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (i_req.op),
        .i_address   (i_req.address),
        .i_count     (i_req.count),
        .i_data      (i_req.data),
        .i_coil_base (r_coil_base),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .o_data_res  (o_res.data_res),
        .o_status    (o_res.status),
        .o_changed   (o_res.changed),
        .o_last      (o_res.last)
    );
endmodule

FILE: tb/sv/packed_coil_table_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for packed_coil_table: directed and random requests,
// each result checked against an in-bench model of the coil store.
// Depends on pct_pkg, pct_if (pct_req_if, pct_res_if) and the block's RTL.
module packed_coil_table_tb;
    import pct_pkg::*;

    localparam int NCOILS      = NUM_COILS_DEF;
    localparam int CLK_HALF    = 4;          // 8 ns period
    localparam int RST_CYCLES  = 10;
    localparam int SETTLE_CYC  = 24;         // > slowest request with no result
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int HOLD_CYC    = 300;        // long result-side hold-off

    // ops 5..7 have no function; the block drops them
    localparam logic [OP_W-1:0]    OP_FIRST_SPARE = 3'd5;
    localparam logic [PADDR_W-1:0] ADDR_COIL_BASE = {REG_COIL_BASE, 2'b00};

    typedef struct packed {
        logic [DATA_W-1:0] data_res;
        logic              status;
        logic              changed;
        logic              last;
    } t_coil_res;

    // ------------------------------------------------------------------
    // Clock, reset, APB and the two channels
    // ------------------------------------------------------------------
    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    pct_req_if req_if ();
    pct_res_if res_if ();

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    packed_coil_table #(
        .NUM_COILS (NCOILS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // ------------------------------------------------------------------
    // Coil store model: a copy of the store, the window base and the
    // progress of an open bus write.
    // ------------------------------------------------------------------
    bit [NCOILS-1:0]    coil_img;
    logic [BASE_W-1:0]  win_base;
    int unsigned        wr_pos;      // store offset of next coil to write
    int unsigned        wr_left;     // coils still owed by the open write
    bit                 wr_dirty;    // open write has flipped a coil
    bit                 wr_bad;      // open write was rejected at its header

    t_coil_res          pending_res[$];   // expected results, oldest first

    int unsigned        items_sent;       // requests that the block acts on
    int                 errors;
    int unsigned        cycle_count;
    bit                 calm;             // no idling on either side
    int                 res_hold_left;    // cycles the result side still holds off

    t_coil_res          got_res;
    t_coil_res          want_res;

    function automatic void queue_res(input logic [DATA_W-1:0] d, input logic st,
                                      input logic ch, input logic lst);
        t_coil_res r;
        r.data_res = d;
        r.status   = st;
        r.changed  = ch;
        r.last     = lst;
        pending_res.push_back(r);
    endfunction

    // Window check for bus ops: the protocol address is 1-based and wraps at 16 bits.
    function automatic bit bus_range(input logic [ADDR_W-1:0] address,
                                     input logic [CNT_W-1:0] count,
                                     output int unsigned offset);
        logic [ADDR_W-1:0] a16;
        int unsigned       a;
        int unsigned       lo;
        a16    = address - 1'b1;
        a      = a16;
        lo     = win_base;
        offset = 0;
        if (count == 0 || a < lo)
            return 1'b0;
        if (a + count > lo + NCOILS)
            return 1'b0;
        offset = a - lo;
        return 1'b1;
    endfunction

    // Updates the model for one accepted request and queues its results.
    // Returns 0 for a request that the block simply drops.
    function automatic bit predict_req(input logic [OP_W-1:0] op,
                                       input logic [ADDR_W-1:0] address,
                                       input logic [CNT_W-1:0] count,
                                       input logic [DATA_W-1:0] data);
        int unsigned       offset;
        int unsigned       nbytes;
        int unsigned       n;
        bit                ok;
        logic [DATA_W-1:0] b;
        predict_req = 1'b1;
        case (op)
            OP_BUS_READ: begin
                nbytes = (count + 7) / 8;
                ok     = bus_range(address, count, offset);
                if (!ok || nbytes > MAX_RESULTS) begin
                    queue_res('0, 1'b1, 1'b0, 1'b1);
                end else begin
                    for (int k = 0; k < nbytes; k++) begin
                        b = '0;
                        for (int i = 0; i < 8; i++)
                            if (k * 8 + i < count)
                                b[i] = coil_img[offset + k * 8 + i];
                        queue_res(b, 1'b0, 1'b0, k + 1 == nbytes);
                    end
                end
            end
            OP_WR_HEADER: begin
                // a header always restarts the write, open or not
                wr_dirty = 1'b0;
                wr_left  = count;
                if (bus_range(address, count, offset)) begin
                    wr_bad = 1'b0;
                    wr_pos = offset;
                end else begin
                    wr_bad = 1'b1;
                    wr_pos = 0;
                end
                if (count == 0)
                    queue_res('0, 1'b1, 1'b0, 1'b1);
            end
            OP_WR_DATA: begin
                if (wr_left == 0)
                    return 1'b0;
                n = (wr_left < 8) ? wr_left : 8;
                if (!wr_bad) begin
                    for (int i = 0; i < n; i++) begin
                        if (coil_img[wr_pos + i] != data[i])
                            wr_dirty = 1'b1;
                        coil_img[wr_pos + i] = data[i];
                    end
                    wr_pos = wr_pos + n;
                end
                wr_left = wr_left - n;
                if (wr_left == 0) begin
                    queue_res('0, wr_bad, !wr_bad && wr_dirty, 1'b1);
                    wr_dirty = 1'b0;
                    wr_bad   = 1'b0;
                    wr_pos   = 0;
                end
            end
            OP_LOC_GET: begin
                if (address < NCOILS)
                    queue_res(DATA_W'(coil_img[address]), 1'b0, 1'b0, 1'b1);
                else
                    queue_res(GET_BAD_BYTE, 1'b1, 1'b0, 1'b1);
            end
            OP_LOC_SET: begin
                if (address < NCOILS) begin
                    coil_img[address] = data[0];
                    queue_res('0, 1'b0, 1'b0, 1'b1);
                end else begin
                    queue_res('0, 1'b1, 1'b0, 1'b1);
                end
            end
            default: predict_req = 1'b0;
        endcase
    endfunction

    function automatic void flag_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------
    // Request driver. Inputs change on the falling edge; valid stays high
    // from one request to the next unless an idle burst is drawn, so
    // back-to-back requests never lower and raise it in one step.
    // ------------------------------------------------------------------
    task automatic send_req(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] address,
                            input logic [CNT_W-1:0] count, input logic [DATA_W-1:0] data);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 5);
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid   = 1'b1;
        req_if.op      = op;
        req_if.address = address;
        req_if.count   = count;
        req_if.data    = data;
        do @(posedge i_clk); while (!req_if.ready);
        if (predict_req(op, address, count, data))
            items_sent++;
    endtask

    // Drop valid, wait for every expected result, then let the block settle
    // in case the last request was one without a result.
    task automatic wait_idle();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (pending_res.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // APB write of coil_base: setup cycle, then access cycle. Upper data
    // bits are junk on purpose, the register keeps only 16.
    task automatic write_coil_base(input logic [BASE_W-1:0] value);
        @(negedge i_clk);
        req_if.valid = 1'b0;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_COIL_BASE;
        pwdata  = {16'($urandom), value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        win_base = value;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random ready bursts, plus a long hold-off on request.
    // ------------------------------------------------------------------
    initial begin : res_sink
        int idle_left;
        idle_left    = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (res_hold_left > 0) begin
                res_hold_left--;
                res_if.ready = 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                res_if.ready = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                idle_left    = $urandom_range(1, 5) - 1;
                res_if.ready = 1'b0;
            end else begin
                res_if.ready = 1'b1;
            end
        end
    end

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got_res.data_res = res_if.data_res;
            got_res.status   = res_if.status;
            got_res.changed  = res_if.changed;
            got_res.last     = res_if.last;
            if (pending_res.size() == 0) begin
                flag_error($sformatf("unexpected result data_res=%02h status=%b changed=%b last=%b",
                                     got_res.data_res, got_res.status, got_res.changed,
                                     got_res.last));
            end else begin
                want_res = pending_res.pop_front();
                if (got_res !== want_res)
                    flag_error($sformatf({"result mismatch: expected data_res=%02h status=%b ",
                                          "changed=%b last=%b, got data_res=%02h status=%b ",
                                          "changed=%b last=%b"},
                                         want_res.data_res, want_res.status, want_res.changed,
                                         want_res.last, got_res.data_res, got_res.status,
                                         got_res.changed, got_res.last));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("packed_coil_table_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Store comes up cleared: the widest legal read and a local get.
    task automatic test_reset_state();
        send_req(OP_BUS_READ, 16'd1, 11'd256, 8'h00);
        send_req(OP_LOC_GET, 16'd0, 11'd0, 8'h00);
    endtask

    // Local get/set by buffer offset, both ends and out of range.
    task automatic test_local_access();
        send_req(OP_LOC_SET, 16'd0, 11'd0, 8'h01);
        send_req(OP_LOC_SET, 16'd255, 11'h7FF, 8'hFF);
        send_req(OP_LOC_SET, 16'd256, 11'd0, 8'h01);    // out of range, no change
        send_req(OP_LOC_GET, 16'd255, 11'd0, 8'h00);
        send_req(OP_LOC_GET, 16'hFFFF, 11'd0, 8'h00);   // out of range
        send_req(OP_LOC_SET, 16'd1, 11'd0, 8'hFE);      // only bit 0 counts
    endtask

    // Bus write: partial last byte, a write that changes nothing, read-back
    // with the unused high bits of the last byte zeroed.
    task automatic test_bus_write();
        send_req(OP_WR_HEADER, 16'd1, 11'd11, 8'h00);
        send_req(OP_WR_DATA, 16'h0000, 11'd0, 8'hA5);
        send_req(OP_WR_DATA, 16'hFFFF, 11'h7FF, 8'hFF); // only 3 coils taken
        send_req(OP_WR_HEADER, 16'd9, 11'd3, 8'h00);
        send_req(OP_WR_DATA, 16'h0000, 11'd0, 8'hFF);   // same values: unchanged
        send_req(OP_BUS_READ, 16'd1, 11'd12, 8'h00);
    endtask

    // Error paths and the requests that the block drops.
    task automatic test_bus_errors();
        send_req(OP_WR_DATA, 16'd1, 11'd1, 8'h55);      // stray byte, no write open
        send_req(OP_BUS_READ, 16'd1, 11'd0, 8'h00);     // zero count
        send_req(OP_BUS_READ, 16'd250, 11'd10, 8'h00);  // runs past the window
        send_req(OP_BUS_READ, 16'd1, 11'h7FF, 8'h00);   // far too many bytes
        send_req(OP_WR_HEADER, 16'd1, 11'd0, 8'h00);    // zero-count header answers at once
        // rejected write: bytes still counted, last one reports the error
        send_req(OP_WR_HEADER, 16'd300, 11'd10, 8'h00);
        send_req(OP_WR_DATA, 16'd0, 11'd0, 8'hFF);
        send_req(OP_WR_DATA, 16'd0, 11'd0, 8'hFF);
        // new header in the middle of a write abandons the open one
        send_req(OP_WR_HEADER, 16'd1, 11'd16, 8'h00);
        send_req(OP_WR_DATA, 16'd0, 11'd0, 8'h3C);
        send_req(OP_WR_HEADER, 16'd17, 11'd3, 8'h00);
        send_req(OP_WR_DATA, 16'd0, 11'd0, 8'h07);
        for (int k = 0; k < 3; k++)
            send_req(OP_FIRST_SPARE + OP_W'(k), 16'd1, 11'd8, 8'hFF);
    endtask

    // Base at the top of the address space: address 0 wraps to the only
    // legal start, address 1 falls below the window, local ops ignore it.
    task automatic test_base_window();
        wait_idle();
        write_coil_base(16'hFFFF);
        send_req(OP_BUS_READ, 16'd0, 11'd256, 8'h00);
        send_req(OP_BUS_READ, 16'd1, 11'd1, 8'h00);
        send_req(OP_LOC_GET, 16'd0, 11'd0, 8'h00);
    endtask

    // Result side holds off for a long stretch while requests keep coming,
    // so the block backs up into its request port; then the sender waits
    // for everything to drain.
    task automatic test_backpressure();
        wait_idle();
        res_hold_left = HOLD_CYC;
        for (int k = 0; k < 10; k++)
            send_req(OP_LOC_GET, ADDR_W'(k), 11'd0, 8'h00);
        for (int k = 0; k < 3; k++)
            send_req(OP_BUS_READ, 16'd0, 11'd64, 8'h00);
        wait_idle();
    endtask

    // Pick a legal span inside the window, mostly short ones.
    function automatic void pick_span(output int unsigned off, output int unsigned cnt);
        int unsigned room;
        off  = $urandom_range(0, NCOILS - 1);
        room = NCOILS - off;
        if ($urandom_range(0, 9) == 0)
            cnt = $urandom_range(1, room);
        else
            cnt = $urandom_range(1, (room < 24) ? room : 24);
    endfunction

    // Random phase at one base: mostly well-formed reads and writes with
    // random content, some broken writes, local ops and raw noise.
    task automatic run_random_phase(input logic [BASE_W-1:0] base, input int unsigned n_items);
        int unsigned       off;
        int unsigned       cnt;
        int unsigned       nbytes;
        int unsigned       pick;
        logic [ADDR_W-1:0] addr;
        wait_idle();
        write_coil_base(base);
        items_sent = 0;
        while (items_sent < n_items) begin
            pick = $urandom_range(0, 99);
            pick_span(off, cnt);
            addr = base + ADDR_W'(off + 1);
            if (pick < 35) begin
                send_req(OP_BUS_READ, addr, CNT_W'(cnt), DATA_W'($urandom));
            end else if (pick < 65) begin
                send_req(OP_WR_HEADER, addr, CNT_W'(cnt), DATA_W'($urandom));
                nbytes = (cnt + 7) / 8;
                // now and then stop short and leave the write open
                if ($urandom_range(0, 6) == 0)
                    nbytes = $urandom_range(0, nbytes - 1);
                repeat (nbytes)
                    send_req(OP_WR_DATA, ADDR_W'($urandom), CNT_W'($urandom),
                             DATA_W'($urandom));
            end else if (pick < 80) begin
                send_req(($urandom_range(0, 1) != 0) ? OP_LOC_SET : OP_LOC_GET,
                         ($urandom_range(0, 7) == 0) ? ADDR_W'($urandom) : ADDR_W'(off),
                         CNT_W'($urandom), DATA_W'($urandom));
            end else begin
                send_req(OP_W'($urandom), ADDR_W'($urandom), CNT_W'($urandom),
                         DATA_W'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        req_if.valid   = 1'b0;
        req_if.op      = OP_BUS_READ;
        req_if.address = '0;
        req_if.count   = '0;
        req_if.data    = '0;
        coil_img       = '0;
        win_base       = '0;
        wr_pos         = 0;
        wr_left        = 0;
        wr_dirty       = 1'b0;
        wr_bad         = 1'b0;
        items_sent     = 0;
        errors         = 0;
        cycle_count    = 0;
        calm           = 1'b0;
        res_hold_left  = 0;

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_local_access();
        test_bus_write();
        test_bus_errors();
        test_base_window();
        test_backpressure();

        run_random_phase(16'h0000, 30);
        run_random_phase(BASE_W'($urandom), 25);  // window may reach past the top
        run_random_phase(16'hFF00, 25);           // window ends at the last address
        calm = 1'b1;                              // closing stretch without idling
        run_random_phase(16'd1000, 30);

        wait_idle();
        if (errors == 0 && pending_res.size() == 0)
            $display("packed_coil_table_tb: done, clean");
        else
            $display("packed_coil_table_tb: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/pct_pkg.sv
rtl/core/pct_if.sv
rtl/core/pct_ram.sv
rtl/core/pct_ctrl.sv
rtl/core/pct_dp.sv
rtl/core/packed_coil_table.sv
tb/sv/packed_coil_table_tb.sv
